>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/ugsp_pkg.sv
// types, constants and helper functions of the grid separation push unit
package ugsp_pkg;

    localparam int GRID_SIDE      = 32;
    localparam int SLOTS_PER_CELL = 8;
    localparam int NCELLS         = GRID_SIDE * GRID_SIDE;
    localparam int NSLOTS         = NCELLS * SLOTS_PER_CELL;
    localparam int CELL_W         = $clog2(GRID_SIDE);
    localparam int COORD_W        = CELL_W + 2;
    localparam int CIDX_W         = $clog2(NCELLS);
    localparam int SADDR_W        = $clog2(NSLOTS);
    localparam int FILL_W         = $clog2(SLOTS_PER_CELL + 1);
    localparam int MAX_NBR        = 9 * SLOTS_PER_CELL;
    localparam int QDEPTH         = 2;

    localparam int POS_W   = 24;
    localparam int ID_W    = 16;
    localparam int PUSH_W  = 18;
    localparam int CNT_W   = 7;
    localparam int SHIFT_W = 4;
    localparam int CMD_W   = 2;

    localparam int RADIUS_Q8   = 896;
    localparam int RADIUS_Q16  = 229376;
    localparam int RADIUS2_Q16 = 802816;
    localparam int MIN2_Q16    = 163;

    localparam int D_W        = 11;
    localparam int ABS_W      = 10;
    localparam int D2_W       = 2 * D_W;
    localparam int SQ_W       = 36;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int SQK_W      = $clog2(SQRT_STEPS);
    localparam int LQ_W       = 18;
    localparam int MULT_W     = 3;
    localparam int GAP_W      = LQ_W + MULT_W;
    localparam int DEN_W      = 28;
    localparam int REM_W      = 40;
    localparam int QUO_W      = 12;
    localparam int QK_W       = $clog2(QUO_W);
    localparam int ACC_W      = 20;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                       op;
        logic [ID_W-1:0]            agent_id;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_z;
        logic                       officer;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cz;
    } item_t;

    typedef struct packed {
        logic full;
        logic sweeping;
    } ctrl_t;

    typedef struct packed {
        logic [ID_W-1:0]  agent_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_z;
        logic             officer;
    } slot_t;

    function automatic logic signed [COORD_W-1:0] cell_coord(
        input logic signed [POS_W-1:0] pos,
        input logic signed [POS_W-1:0] org,
        input logic [SHIFT_W-1:0]      sh
    );
        logic [POS_W:0]       off;
        logic [POS_W:0]       mag;
        logic [POS_W:0]       shd;
        logic [SHIFT_W:0]     amt;
        logic [COORD_W-1:0]   m;
        off = {pos[POS_W-1], pos} - {org[POS_W-1], org};
        mag = off[POS_W] ? (~off + 1'b1) : off;
        amt = {1'b0, sh} + (SHIFT_W+1)'(8);
        shd = mag >> amt;
        if (shd > (POS_W+1)'(GRID_SIDE / 2 + 2))
            m = COORD_W'(GRID_SIDE / 2 + 2);
        else
            m = shd[COORD_W-1:0];
        return off[POS_W] ? COORD_W'(GRID_SIDE / 2) - m : COORD_W'(GRID_SIDE / 2) + m;
    endfunction

    function automatic logic in_grid(input logic signed [COORD_W-1:0] c);
        return !c[COORD_W-1] && (c < COORD_W'(GRID_SIDE));
    endfunction

    function automatic logic [CIDX_W-1:0] cell_index(
        input logic signed [COORD_W-1:0] cx,
        input logic signed [COORD_W-1:0] cz
    );
        logic [CIDX_W-1:0] a;
        logic [CIDX_W-1:0] b;
        a = CIDX_W'(cx[CELL_W-1:0]);
        b = CIDX_W'(cz[CELL_W-1:0]);
        return a * CIDX_W'(GRID_SIDE) + b;
    endfunction

    function automatic logic [SADDR_W-1:0] slot_addr(
        input logic [CIDX_W-1:0] c,
        input logic [FILL_W-1:0] j
    );
        return SADDR_W'(c) * SADDR_W'(SLOTS_PER_CELL) + SADDR_W'(j);
    endfunction

endpackage

>>> rtl/ugsp_front.sv
// front end: takes requests, keeps the origin and works out cell coordinates
module ugsp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ugsp_pkg::CMD_W-1:0]          cmd,
    input  logic [ugsp_pkg::ID_W-1:0]           agent_id,
    input  logic signed [ugsp_pkg::POS_W-1:0]   pos_x,
    input  logic signed [ugsp_pkg::POS_W-1:0]   pos_z,
    input  logic                                is_officer,
    input  logic [ugsp_pkg::SHIFT_W-1:0]        cell_shift,
    input  ugsp_pkg::ctrl_t                     ctrl,
    output logic                                push,
    output ugsp_pkg::item_t                     push_item
);
    import ugsp_pkg::*;

    logic signed [POS_W-1:0] origin_x_reg;
    logic signed [POS_W-1:0] origin_z_reg;
    logic                    accept;

    assign in_stall = ctrl.full || ctrl.sweeping;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (cmd_t'(cmd) != CMD_NONE);

    always_comb
    begin
        push_item.op       = cmd_t'(cmd);
        push_item.agent_id = agent_id;
        push_item.pos_x    = pos_x;
        push_item.pos_z    = pos_z;
        push_item.officer  = is_officer;
        push_item.cx       = cell_coord(pos_x, origin_x_reg, cell_shift);
        push_item.cz       = cell_coord(pos_z, origin_z_reg, cell_shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (accept && cmd_t'(cmd) == CMD_CLEAR)
        begin
            origin_x_reg <= pos_x;
            origin_z_reg <= pos_z;
        end
    end

endmodule

>>> rtl/ugsp_queue.sv
// short request queue between front and back end
module ugsp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ugsp_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output ugsp_pkg::item_t head
);
    import ugsp_pkg::*;

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/ugsp_back.sv
// back end: grid memories, insert, clearing pass and the neighbor scan with push math
module ugsp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  ugsp_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                sweeping,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ugsp_pkg::PUSH_W-1:0]  push_x,
    output logic signed [ugsp_pkg::PUSH_W-1:0]  push_z,
    output logic [ugsp_pkg::CNT_W-1:0]          neighbor_count
);
    import ugsp_pkg::*;

    typedef enum logic [14:0] {
        ST_SWEEP  = 15'b000000000000001,
        ST_IDLE   = 15'b000000000000010,
        ST_INS_RD = 15'b000000000000100,
        ST_INS_WR = 15'b000000000001000,
        ST_CELL   = 15'b000000000010000,
        ST_FILL   = 15'b000000000100000,
        ST_SLOT   = 15'b000000001000000,
        ST_DATA   = 15'b000000010000000,
        ST_SQ     = 15'b000000100000000,
        ST_SQRT   = 15'b000001000000000,
        ST_PREP   = 15'b000010000000000,
        ST_MUL    = 15'b000100000000000,
        ST_DIV    = 15'b001000000000000,
        ST_ACC    = 15'b010000000000000,
        ST_RESULT = 15'b100000000000000
    } state_t;

    localparam logic signed [POS_W:0] RLIM = (POS_W+1)'(RADIUS_Q8);

    function automatic logic signed [PUSH_W-1:0] sat_push(input logic signed [ACC_W-1:0] v);
        if (v > $signed(ACC_W'((1 << (PUSH_W - 1)) - 1)))
            return PUSH_W'((1 << (PUSH_W - 1)) - 1);
        else if (v < -$signed(ACC_W'(1 << (PUSH_W - 1))))
            return PUSH_W'(1 << (PUSH_W - 1));
        else
            return v[PUSH_W-1:0];
    endfunction

    state_t                   state_reg, state_next;
    logic [CIDX_W-1:0]        sweep_reg;
    item_t                    item_reg;
    logic [1:0]               ddx_reg, ddz_reg;
    logic [FILL_W-1:0]        fill_cnt_reg, j_reg;
    logic signed [D_W-1:0]    dx_reg, dz_reg;
    logic [MULT_W-1:0]        mult_reg;
    logic [SQ_W-1:0]          v_reg, res_reg;
    logic [SQK_W-1:0]         k_reg;
    logic [GAP_W-1:0]         gap_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [QK_W-1:0]          qk_reg;
    logic                     comp_z_reg;
    logic signed [ACC_W-1:0]  sum_x_reg, sum_z_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     out_valid_reg;
    logic signed [PUSH_W-1:0] push_x_reg, push_z_reg;
    logic [CNT_W-1:0]         count_out_reg;

    logic [FILL_W-1:0]        fill_mem [NCELLS];
    logic [FILL_W-1:0]        fill_rd_reg;
    slot_t                    slot_mem [NSLOTS];
    slot_t                    slot_rd_reg;

    logic signed [COORD_W-1:0] nx, nz;
    logic [CIDX_W-1:0]         cell_addr, item_cell, fill_addr;
    logic                      fill_we;
    logic [FILL_W-1:0]         fill_wdata;
    logic [SADDR_W-1:0]        slot_a;
    logic                      slot_we;
    slot_t                     slot_wdata;
    logic                      last_cell, nbr_in_grid, can_insert;
    logic signed [POS_W:0]     sdx, sdz;
    logic                      near, skip;
    logic signed [D2_W-1:0]    sqx, sqz;
    logic [D2_W-1:0]           d2;
    logic                      in_window;
    logic [SQ_W-1:0]           sbit, strial;
    logic [LQ_W-1:0]           lq;
    logic signed [D_W-1:0]     dsel;
    logic [ABS_W-1:0]          dabs;
    logic [REM_W-1:0]          dsh;
    logic                      ge;
    logic signed [ACC_W-1:0]   qsigned;
    logic                      out_free;

    assign nx          = item_reg.cx + COORD_W'(ddx_reg) - COORD_W'(1);
    assign nz          = item_reg.cz + COORD_W'(ddz_reg) - COORD_W'(1);
    assign cell_addr   = cell_index(nx, nz);
    assign item_cell   = cell_index(item_reg.cx, item_reg.cz);
    assign last_cell   = (ddx_reg == 2'd2) && (ddz_reg == 2'd2);
    assign nbr_in_grid = in_grid(nx) && in_grid(nz);
    assign can_insert  = fill_rd_reg < FILL_W'(SLOTS_PER_CELL);

    assign sdx  = $signed({item_reg.pos_x[POS_W-1], item_reg.pos_x})
                - $signed({slot_rd_reg.pos_x[POS_W-1], slot_rd_reg.pos_x});
    assign sdz  = $signed({item_reg.pos_z[POS_W-1], item_reg.pos_z})
                - $signed({slot_rd_reg.pos_z[POS_W-1], slot_rd_reg.pos_z});
    assign near = (sdx < RLIM) && (sdx > -RLIM) && (sdz < RLIM) && (sdz > -RLIM);
    assign skip = (slot_rd_reg.agent_id == item_reg.agent_id) || !near;

    assign sqx       = dx_reg * dx_reg;
    assign sqz       = dz_reg * dz_reg;
    assign d2        = D2_W'(sqx) + D2_W'(sqz);
    assign in_window = (d2 < D2_W'(RADIUS2_Q16)) && (d2 > D2_W'(MIN2_Q16));

    assign sbit   = SQ_W'(1) << {k_reg, 1'b0};
    assign strial = res_reg + sbit;
    assign lq     = res_reg[LQ_W-1:0];

    assign dsel    = comp_z_reg ? dz_reg : dx_reg;
    assign dabs    = dsel[D_W-1] ? ABS_W'(-dsel) : ABS_W'(dsel);
    assign dsh     = REM_W'(den_reg) << qk_reg;
    assign ge      = rem_reg >= dsh;
    assign qsigned = dsel[D_W-1] ? -$signed(ACC_W'(quo_reg)) : $signed(ACC_W'(quo_reg));

    assign out_free = !out_valid_reg || !out_stall;

    assign sweeping       = (state_reg == ST_SWEEP);
    assign q_pop          = (state_reg == ST_IDLE) && q_valid;
    assign out_valid      = out_valid_reg;
    assign push_x         = push_x_reg;
    assign push_z         = push_z_reg;
    assign neighbor_count = count_out_reg;

    always_comb
    begin
        fill_addr  = cell_addr;
        fill_we    = 1'b0;
        fill_wdata = '0;
        slot_a     = slot_addr(cell_addr, j_reg);
        slot_we    = 1'b0;
        slot_wdata.agent_id = item_reg.agent_id;
        slot_wdata.pos_x    = item_reg.pos_x;
        slot_wdata.pos_z    = item_reg.pos_z;
        slot_wdata.officer  = item_reg.officer;
        case (state_reg)
            ST_SWEEP:
            begin
                fill_addr = sweep_reg;
                fill_we   = 1'b1;
            end
            ST_INS_RD:
            begin
                fill_addr = item_cell;
            end
            ST_INS_WR:
            begin
                fill_addr  = item_cell;
                fill_we    = can_insert;
                fill_wdata = fill_rd_reg + 1'b1;
                slot_a     = slot_addr(item_cell, fill_rd_reg);
                slot_we    = can_insert;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_addr] <= fill_wdata;
        fill_rd_reg <= fill_mem[fill_addr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_a] <= slot_wdata;
        slot_rd_reg <= slot_mem[slot_a];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
                if (sweep_reg == CIDX_W'(NCELLS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                begin
                    case (q_item.op)
                        CMD_CLEAR:
                            state_next = ST_SWEEP;
                        CMD_INSERT:
                            state_next = (in_grid(q_item.cx) && in_grid(q_item.cz))
                                       ? ST_INS_RD : ST_IDLE;
                        CMD_QUERY:
                            state_next = ST_CELL;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            ST_INS_RD:
                state_next = ST_INS_WR;
            ST_INS_WR:
                state_next = ST_IDLE;
            ST_CELL:
                if (nbr_in_grid)
                    state_next = ST_FILL;
                else if (last_cell)
                    state_next = ST_RESULT;
            ST_FILL:
                state_next = ST_SLOT;
            ST_SLOT:
                if (j_reg < fill_cnt_reg)
                    state_next = ST_DATA;
                else
                    state_next = last_cell ? ST_RESULT : ST_CELL;
            ST_DATA:
                state_next = skip ? ST_SLOT : ST_SQ;
            ST_SQ:
                state_next = in_window ? ST_SQRT : ST_SLOT;
            ST_SQRT:
                if (k_reg == '0)
                    state_next = ST_PREP;
            ST_PREP:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (qk_reg == '0)
                    state_next = ST_ACC;
            ST_ACC:
                state_next = comp_z_reg ? ST_SLOT : ST_MUL;
            ST_RESULT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
                sweep_reg <= sweep_reg + 1'b1;
            else
                sweep_reg <= '0;
            if (state_reg == ST_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // scan counters, square root and divider datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg  <= q_item;
                ddx_reg   <= '0;
                ddz_reg   <= '0;
                sum_x_reg <= '0;
                sum_z_reg <= '0;
                cnt_reg   <= '0;
            end
            ST_CELL, ST_SLOT:
            begin
                if ((state_reg == ST_CELL && !nbr_in_grid)
                    || (state_reg == ST_SLOT && j_reg >= fill_cnt_reg))
                begin
                    if (ddz_reg == 2'd2)
                    begin
                        ddz_reg <= '0;
                        ddx_reg <= ddx_reg + 1'b1;
                    end
                    else
                        ddz_reg <= ddz_reg + 1'b1;
                end
                if (state_reg == ST_SLOT && j_reg < fill_cnt_reg)
                    j_reg <= j_reg + 1'b1;
            end
            ST_FILL:
            begin
                fill_cnt_reg <= fill_rd_reg;
                j_reg        <= '0;
            end
            ST_DATA:
            begin
                dx_reg   <= sdx[D_W-1:0];
                dz_reg   <= sdz[D_W-1:0];
                mult_reg <= item_reg.officer ? MULT_W'(6)
                          : (slot_rd_reg.officer ? MULT_W'(2) : MULT_W'(4));
            end
            ST_SQ:
            begin
                v_reg   <= SQ_W'({d2, 16'b0});
                res_reg <= '0;
                k_reg   <= SQK_W'(SQRT_STEPS - 1);
            end
            ST_SQRT:
            begin
                if (v_reg >= strial)
                begin
                    v_reg   <= v_reg - strial;
                    res_reg <= (res_reg >> 1) + sbit;
                end
                else
                    res_reg <= res_reg >> 1;
                k_reg <= k_reg - 1'b1;
            end
            ST_PREP:
            begin
                gap_reg    <= GAP_W'(LQ_W'(RADIUS_Q16) - lq) * GAP_W'(mult_reg);
                den_reg    <= DEN_W'(lq) * DEN_W'(RADIUS_Q8);
                comp_z_reg <= 1'b0;
            end
            ST_MUL:
            begin
                rem_reg <= (REM_W'(dabs) * REM_W'(gap_reg)) << 8;
                quo_reg <= '0;
                qk_reg  <= QK_W'(QUO_W - 1);
            end
            ST_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh;
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                qk_reg  <= qk_reg - 1'b1;
            end
            ST_ACC:
            begin
                if (comp_z_reg)
                begin
                    sum_z_reg <= sum_z_reg + qsigned;
                    if (cnt_reg != '1)
                        cnt_reg <= cnt_reg + 1'b1;
                end
                else
                    sum_x_reg <= sum_x_reg + qsigned;
                comp_z_reg <= 1'b1;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    push_x_reg    <= sat_push(sum_x_reg);
                    push_z_reg    <= sat_push(sum_z_reg);
                    count_out_reg <= cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/uniform_grid_separation_push_unit.sv
// top level of the uniform grid separation push unit
// Requests are clear (set origin, empty the grid), insert and query; only a
// query returns a result. After reset and after every clear the unit runs a
// clearing pass over the GRID_SIDE*GRID_SIDE (1024) cell fill counts during
// which no request is taken. An insert reads the fill count of its cell and,
// if the cell has room, writes the slot and the new count. A query scans
// the neighboring cells inside the grid and their stored slots; for each
// neighbor inside the radius it runs the 18-step bit-serial square root and
// two passes of the shared 12-step restoring divider. The front end keeps
// the origin and computes the cell coordinates, and a two-entry queue lets
// it take further requests while the back end works; a result waits in the
// output register.
module uniform_grid_separation_push_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ugsp_pkg::CMD_W-1:0]          cmd,
    input  logic [ugsp_pkg::ID_W-1:0]           agent_id,
    input  logic signed [ugsp_pkg::POS_W-1:0]   pos_x,
    input  logic signed [ugsp_pkg::POS_W-1:0]   pos_z,
    input  logic                                is_officer,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ugsp_pkg::PUSH_W-1:0]  push_x,
    output logic signed [ugsp_pkg::PUSH_W-1:0]  push_z,
    output logic [ugsp_pkg::CNT_W-1:0]          neighbor_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ugsp_pkg::SHIFT_W-1:0]        cfg_data
);
    import ugsp_pkg::*;

    logic [SHIFT_W-1:0] cell_shift_reg;
    ctrl_t              ctrl;
    logic               q_push;
    item_t              q_push_item;
    logic               q_pop;
    logic               q_not_empty;
    item_t              q_head;
    logic               q_full;
    logic               b_sweeping;

    assign cfg_ready     = 1'b1;
    assign ctrl.full     = q_full;
    assign ctrl.sweeping = b_sweeping;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_shift_reg <= SHIFT_W'(2);
        else if (cfg_valid && cfg_ready)
            cell_shift_reg <= cfg_data;
    end

    ugsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .agent_id   (agent_id),
        .pos_x      (pos_x),
        .pos_z      (pos_z),
        .is_officer (is_officer),
        .cell_shift (cell_shift_reg),
        .ctrl       (ctrl),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    ugsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ugsp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_not_empty),
        .q_item         (q_head),
        .q_pop          (q_pop),
        .sweeping       (b_sweeping),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .push_x         (push_x),
        .push_z         (push_z),
        .neighbor_count (neighbor_count)
    );

`include "assert_macros.svh"

    `ASSERT_IMPL(a_push_not_full, q_push, !q_full, "request pushed into full queue")
    `ASSERT_IMPL(a_no_request_in_sweep, in_valid && !in_stall, !b_sweeping, "request taken during clearing pass")
    `ASSERT_IMPL(a_count_bound, out_valid, neighbor_count <= CNT_W'(MAX_NBR), "neighbor count above grid bound")
    `ASSERT_NEXT(a_pop_has_entry, q_pop && !q_not_empty, 1'b0, "pop from empty queue")

endmodule
